// ----- design/clip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_pkg
// Shared types and constants of the console line input packer.
// ----------------------------------------------------------------------------
package clip_pkg;

   // Line geometry
   localparam int LINE_BYTES = 81;
   localparam int CHARS_PER_WORD = 4;
   localparam int ROWS = (LINE_BYTES + CHARS_PER_WORD - 1) / CHARS_PER_WORD;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FILL_W = $clog2(LINE_BYTES + 1);
   localparam int MAX_WORDS = 21;
   localparam int WCNT_W = $clog2(MAX_WORDS + 1);

   // Field widths
   localparam int KEY_W = 7;
   localparam int TALLY_IN_W = 12;
   localparam int TALLY_W = 13;
   localparam int WAIT_W = 20;
   localparam int CHAR_W = 9;
   localparam int DATA_W = 36;
   localparam int MODE_W = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [WAIT_W-1:0] TIMEOUT_RESET = WAIT_W'(30);
   localparam logic [TALLY_W-1:0] TALLY_FULL = TALLY_W'(4096);

   // Item modes
   localparam logic [MODE_W-1:0] MODE_KEY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_NUL = 7'h00;
   localparam logic [KEY_W-1:0] KEY_EOT = 7'h04;
   localparam logic [KEY_W-1:0] KEY_BS = 7'h08;
   localparam logic [KEY_W-1:0] KEY_LF = 7'h0A;
   localparam logic [KEY_W-1:0] KEY_CR = 7'h0D;
   localparam logic [KEY_W-1:0] KEY_NAK = 7'h15;
   localparam logic [KEY_W-1:0] KEY_SUB = 7'h1A;
   localparam logic [KEY_W-1:0] KEY_ESC = 7'h1B;
   localparam logic [KEY_W-1:0] KEY_SPACE = 7'h20;
   localparam logic [KEY_W-1:0] KEY_TILDE = 7'h7E;
   localparam logic [KEY_W-1:0] KEY_DEL = 7'h7F;

   // Line store write from the front end
   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      logic [1:0]       lane;
      logic [KEY_W-1:0] data;
   } wr_type;

   // Command queued from front to back
   typedef struct packed {
      logic              attn;
      logic              status;
      logic [FILL_W-1:0] fill;
      logic [WCNT_W-1:0] words;
   } cmd_type;

endpackage

// ----- design/clip_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module clip_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clip_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output clip_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import clip_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ----- design/clip_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_front
// Accepts items, edits the line, tracks the read and queues completions.
// ----------------------------------------------------------------------------
module clip_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [clip_pkg::WAIT_W-1:0]      csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [clip_pkg::MODE_W-1:0]      req_mode,
   input  logic [clip_pkg::KEY_W-1:0]       req_key,
   input  logic [clip_pkg::TALLY_IN_W-1:0]  req_tally,
   output clip_pkg::wr_type                 line_wr,
   output logic                             cmd_push,
   output clip_pkg::cmd_type                cmd,
   input  logic                             cmd_full,
   input  logic                             line_done
);
   import clip_pkg::*;

   logic               reading_ff, reading_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [WAIT_W-1:0]  timeout_ff;
   logic               pending_ff;

   logic               accept;
   logic               finish;
   logic               finish_status;
   logic [FILL_W-1:0]  finish_fill;
   logic               attn;
   logic [FILL_W:0]    ceil_sum;
   logic [TALLY_W-1:0] words_ceil;
   logic [TALLY_W-1:0] words_tally;
   logic [WCNT_W-1:0]  words;

   // Stall while a line is being sent out, since it shares the store, or while the command queue is full
   assign req_tready = !pending_ff && !cmd_full;
   assign accept = req_tvalid && req_tready;

   // Classify the item and compute the next read state
   always_comb begin
      reading_in = reading_ff;
      fill_in = fill_ff;
      tally_in = tally_ff;
      wait_in = wait_ff;
      finish = 1'b0;
      finish_status = 1'b0;
      finish_fill = fill_ff;
      attn = 1'b0;
      line_wr.en = 1'b0;
      line_wr.row = ROW_W'(fill_ff >> 2);
      line_wr.lane = fill_ff[1:0];
      line_wr.data = req_key;
      case (req_mode)
         MODE_START: begin
            reading_in = 1'b1;
            fill_in = '0;
            tally_in = (req_tally == '0) ? TALLY_FULL : TALLY_W'(req_tally);
            wait_in = '0;
         end
         MODE_IDLE: begin
            reading_in = 1'b0;
         end
         MODE_TICK: begin
            if (reading_ff) begin
               if (wait_ff != {WAIT_W{1'b1}}) begin
                  wait_in = wait_ff + WAIT_W'(1);
               end
               if (fill_ff == '0 && wait_in > timeout_ff) begin
                  finish = 1'b1;
                  finish_status = 1'b1;
               end
            end
         end
         default: begin
            if (req_key == KEY_NUL) begin
               // ignore
            end else if (!reading_ff) begin
               attn = (req_key == KEY_ESC);
            end else if (req_key == KEY_DEL || req_key == KEY_BS) begin
               if (fill_ff != '0) begin
                  fill_in = fill_ff - FILL_W'(1);
               end
            end else if (req_key == KEY_NAK) begin
               fill_in = '0;
            end else if (req_key == KEY_CR || req_key == KEY_LF) begin
               finish = 1'b1;
            end else if (req_key == KEY_ESC || req_key == KEY_EOT ||
                         req_key == KEY_SUB) begin
               finish = 1'b1;
               finish_status = 1'b1;
               finish_fill = '0;
            end else if (req_key >= KEY_SPACE && req_key <= KEY_TILDE) begin
               if (fill_ff < FILL_W'(LINE_BYTES)) begin
                  line_wr.en = accept;
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
         end
      endcase

      // Word count: packed length limited by tally and result budget
      ceil_sum = (FILL_W + 1)'(finish_fill) + (FILL_W + 1)'(3);
      words_ceil = TALLY_W'(ceil_sum >> 2);
      words_tally = (words_ceil > tally_ff) ? tally_ff : words_ceil;
      words = (words_tally > TALLY_W'(MAX_WORDS)) ? WCNT_W'(MAX_WORDS)
                                                  : WCNT_W'(words_tally);
      if (finish) begin
         tally_in = tally_ff - TALLY_W'(words);
         fill_in = '0;
         reading_in = 1'b0;
      end

      cmd_push = accept && (finish || attn);
      cmd.attn = attn;
      cmd.status = finish_status;
      cmd.fill = finish_fill;
      cmd.words = finish ? words : '0;
   end

   // Hold read state, timeout register and completion tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff <= 1'b0;
         fill_ff <= '0;
         tally_ff <= '0;
         wait_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
         pending_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (accept) begin
            reading_ff <= reading_in;
            fill_ff <= fill_in;
            tally_ff <= tally_in;
            wait_ff <= wait_in;
         end
         if (accept && finish) begin
            pending_ff <= 1'b1;
         end else if (line_done) begin
            pending_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- design/clip_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_back
// Holds the line store and sends queued completions as packed words.
// ----------------------------------------------------------------------------
module clip_back (
   input  logic                                clock,
   input  logic                                reset,
   input  clip_pkg::wr_type                    line_wr,
   input  logic                                cmd_empty,
   input  clip_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   output logic                                line_done,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [clip_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import clip_pkg::*;

   typedef enum logic {ST_IDLE, ST_SEND} state_type;

   localparam int POS_W = ROW_W + FILL_W + 2;

   logic [CHARS_PER_WORD-1:0][KEY_W-1:0] line_mem [ROWS];
   logic [CHARS_PER_WORD-1:0][KEY_W-1:0] rd_data_ff;

   state_type          state_ff;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [WCNT_W-1:0]  words_ff;
   logic               status_ff;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               row_end;
   logic               rsp_load;
   logic [DATA_W-1:0]  packed_word;
   logic [POS_W-1:0]   pos;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign row_end = (WCNT_W'(row_ff) == words_ff - WCNT_W'(1));
   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty && out_free;
   assign line_done = (cmd_pop && !cmd.attn && cmd.words == '0) ||
                      (state_ff == ST_SEND && out_free && row_end);
   assign rsp_load = (state_ff == ST_SEND) ? out_free
                                           : (cmd_pop && (cmd.attn || cmd.words == '0));

   // Pick the next row to read
   always_comb begin
      row_in = row_ff;
      if (state_ff == ST_IDLE) begin
         row_in = '0;
      end else if (out_free && !row_end) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   // Pack one row, zeroing slots past the end of the line
   always_comb begin
      packed_word = '0;
      pos = '0;
      for (int k = 0; k < CHARS_PER_WORD; k++) begin
         pos = POS_W'({row_ff, 2'(k)});
         if (pos < POS_W'(fill_ff)) begin
            packed_word[DATA_W-1-CHAR_W*k -: CHAR_W] = CHAR_W'(rd_data_ff[k]);
         end
      end
   end

   // Line store: byte-lane write, registered row read
   always_ff @(posedge clock) begin
      if (line_wr.en) begin
         line_mem[line_wr.row][line_wr.lane] <= line_wr.data;
      end
      rd_data_ff <= line_mem[row_in];
   end

   // Sequence completions and hold the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= '0;
         fill_ff <= '0;
         words_ff <= '0;
         status_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
         rsp_last_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         // Load a new result or drop the one just taken
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  if (cmd.attn) begin
                     rsp_data_ff <= {1'b1, 1'b0, 1'b0, {DATA_W{1'b0}}, 1'b0};
                     rsp_last_ff <= 1'b1;
                  end else if (cmd.words == '0) begin
                     rsp_data_ff <= {1'b0, cmd.status, 1'b1, {DATA_W{1'b0}}, 1'b0};
                     rsp_last_ff <= 1'b1;
                  end else begin
                     fill_ff <= cmd.fill;
                     words_ff <= cmd.words;
                     status_ff <= cmd.status;
                     state_ff <= ST_SEND;
                  end
               end
            end
            ST_SEND: begin
               if (out_free) begin
                  rsp_data_ff <= {1'b0, status_ff && row_end, row_end,
                                  packed_word, 1'b1};
                  rsp_last_ff <= row_end;
                  if (row_end) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- design/console_line_input_packer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_input_packer_top
// Operator-console line editor that packs a finished line into 36-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: tuser holds the mode (keystroke,
//   start read, tick, back to idle), tdata the key code and word tally.
//   rsp_* returns results; tlast marks the final result of an item.
//   csr_wr_en / csr_wr_data write the timeout in ticks (reset value 30).
// Flow:
//   Items that edit the line or cause no result are taken whenever
//   req_tready is high. An attention result or an empty completion passes
//   through the command queue into the output register on rsp_*. A
//   completion with N words, at most 21 for a full line, is read row by
//   row from the line store and sent as one word per cycle while
//   rsp_tready is high; the next item is taken after the last word. Input is
//   held off while a completion is outstanding, as the single line store
//   serves both the editing front end and the packing back end.
// Reset: synchronous; the read drops, the line empties, the timeout
//   returns to 30 and no result is pending. Line contents are not cleared.
// Stall: a held rsp_tready freezes the output register; the command queue
//   then fills and req_tready drops.
// ----------------------------------------------------------------------------
module console_line_input_packer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [clip_pkg::WAIT_W-1:0]         csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: key_code[6:0], word_tally[18:7], zero fill [23:19]
   input  logic [clip_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: mode[1:0]
   input  logic [clip_pkg::MODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: word_valid[0], data_word[36:1], read_done[37], end_status[38],
   //        attention[39]
   output logic [clip_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import clip_pkg::*;

   wr_type  line_wr;
   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    cmd_push;
   logic    cmd_pop;
   logic    cmd_full;
   logic    cmd_empty;
   logic    line_done;

   // Front end: edit and classify
   clip_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_mode    (req_tuser),
      .req_key     (req_tdata[KEY_W-1:0]),
      .req_tally   (req_tdata[KEY_W+TALLY_IN_W-1:KEY_W]),
      .line_wr     (line_wr),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .cmd_full    (cmd_full),
      .line_done   (line_done)
   );

   // Command queue
   clip_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .pop_cmd  (pop_cmd),
      .empty    (cmd_empty)
   );

   // Back end: pack and send
   clip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .line_wr    (line_wr),
      .cmd_empty  (cmd_empty),
      .cmd        (pop_cmd),
      .cmd_pop    (cmd_pop),
      .line_done  (line_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
